// ===== src/postfix_stack_evaluator_macros.svh =====
// assertion macros for the postfix stack evaluator
// expects clk and rst_n in the scope of each use
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// condition holds in the same cycle
`define PSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pse assertion failed");

// condition holds in the next cycle
`define PSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pse assertion failed");

`endif

// ===== src/pse_pkg.sv =====
// shared types and constants for the postfix stack evaluator
// no dependencies
package pse_pkg;

  localparam int DATA_W            = 32;
  localparam int STACK_DEPTH_DEF   = 16;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_END  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_res_t;

endpackage

// ===== src/pse_if.sv =====
// request channels of the postfix stack evaluator: commands in, results out
// depends on nothing beyond the field widths of the block
interface pse_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] operand_value;

  modport source (output valid, command, operand_value, input ready);
  modport sink   (input valid, command, operand_value, output ready);
endinterface

interface pse_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [1:0]         status;
  logic               expression_done;

  modport source (output valid, top_value, status, expression_done, input ready);
  modport sink   (input valid, top_value, status, expression_done, output ready);
endinterface

// ===== src/postfix_stack_evaluator.sv =====
// postfix expression evaluator: top level with the operand stack memory
// depends on pse_pkg, pse_if, pse_div and the assertion macro header
//
// in_cmd carries one command per request: push, add, subtract, multiply,
// divide or end of expression, with the operand used by push.
// out_res returns exactly one result per command: the new top of stack,
// a status code and a flag that marks the final value of an expression.
// Operands live in a synchronous memory of STACK_DEPTH words with one write
// and one read port; the top of stack is also kept in a register, so an
// operator reads only the left operand from memory, at the accepting edge.
// A command is registered at the accepting edge, executed in S_EXEC and its
// result registered in the output register; no new command is taken until
// the block is back in S_IDLE. Divide runs through a bit-serial divider,
// and its result is registered once the divider signals done.
// Reset empties the stack at once; no memory clearing pass is needed.
// A result waiting on a stalled receiver is held in the output register
// while the next command is accepted and executed; its result is parked
// in a holding register until the output is free.
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  pse_cmd_if.sink        in_cmd,
  pse_res_if.source      out_res
);
  import pse_pkg::*;

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [2:0]        cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [IdxW-1:0]   rd_addr;

  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              fin;
  logic [DATA_W-1:0] fin_top;
  status_t           fin_status;
  logic              fin_done;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_top_r;
  status_t           out_status_r;
  logic              out_done_r;
  logic [DATA_W-1:0] pend_top_r;
  status_t           pend_status_r;
  logic              pend_done_r;

  logic              accept;
  logic              slot_free;
  logic              div_start;
  div_res_t          div_res;
  logic [DATA_W-1:0] arith_res;
  logic [IdxW-1:0]   left_addr;

  assign accept    = in_cmd.valid && in_cmd.ready;
  assign slot_free = !out_valid_r || out_res.ready;
  assign left_addr = IdxW'(cnt_r - CntW'(2));
  assign rd_addr   = left_addr;

  pse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rd_data_r),
    .den   (top_r),
    .res   (div_res)
  );

  always_comb begin
    case (cmd_r)
      CMD_ADD: arith_res = rd_data_r + top_r;
      CMD_SUB: arith_res = rd_data_r - top_r;
      CMD_MUL: arith_res = rd_data_r * top_r;
      default: arith_res = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    wr_en      = 1'b0;
    wr_addr    = left_addr;
    wr_data    = arith_res;
    fin        = 1'b0;
    fin_top    = top_r;
    fin_status = ST_OK;
    fin_done   = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        fin = 1'b1;
        case (cmd_r)
          CMD_PUSH: begin
            if (cnt_r == CntW'(STACK_DEPTH)) begin
              fin_status = ST_OVERFLOW;
            end else begin
              wr_en   = 1'b1;
              wr_addr = IdxW'(cnt_r);
              wr_data = val_r;
              cnt_nxt = cnt_r + CntW'(1);
              top_nxt = val_r;
              fin_top = val_r;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (cnt_r < CntW'(2)) begin
              fin_status = ST_UNDERFLOW;
            end else if (cmd_r == CMD_DIV) begin
              if (top_r == '0) begin
                fin_status = ST_DIVZERO;
              end else begin
                fin       = 1'b0;
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end else begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r - CntW'(1);
              top_nxt = arith_res;
              fin_top = arith_res;
            end
          end
          CMD_END: begin
            fin_done = 1'b1;
            if (cnt_r == '0) fin_status = ST_UNDERFLOW;
            cnt_nxt = '0;
            top_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_res.done) begin
          fin     = 1'b1;
          wr_en   = 1'b1;
          wr_data = div_res.quotient;
          cnt_nxt = cnt_r - CntW'(1);
          top_nxt = div_res.quotient;
          fin_top = div_res.quotient;
        end
      end
      S_WAIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (fin) state_nxt = slot_free ? S_IDLE : S_WAIT;
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
      if (fin && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (state_r == S_WAIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      cmd_r <= in_cmd.command;
      val_r <= in_cmd.operand_value;
    end
    if (fin && slot_free) begin
      out_top_r    <= fin_top;
      out_status_r <= fin_status;
      out_done_r   <= fin_done;
    end else if (state_r == S_WAIT && slot_free) begin
      out_top_r    <= pend_top_r;
      out_status_r <= pend_status_r;
      out_done_r   <= pend_done_r;
    end
    if (fin && !slot_free) begin
      pend_top_r    <= fin_top;
      pend_status_r <= fin_status;
      pend_done_r   <= fin_done;
    end
  end

  assign in_cmd.ready            = (state_r == S_IDLE);
  assign out_res.valid           = out_valid_r;
  assign out_res.top_value       = out_top_r;
  assign out_res.status          = out_status_r;
  assign out_res.expression_done = out_done_r;

  `PSE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CntW'(STACK_DEPTH))
  `PSE_ASSERT_IMP(a_empty_top, cnt_r == '0, top_r == '0)
  `PSE_ASSERT_NXT(a_accept_exec, accept, state_r == S_EXEC)
  `PSE_ASSERT_IMP(a_wait_full, state_r == S_WAIT, out_valid_r)
  `PSE_ASSERT_IMP(a_div_state, div_res.done, state_r == S_DIV)

endmodule

// ===== src/pse_div.sv =====
// signed 32-bit truncating divider, one quotient bit per cycle
// depends on pse_pkg
module pse_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pse_pkg::DATA_W-1:0]  num,
  input  logic [pse_pkg::DATA_W-1:0]  den,
  output pse_pkg::div_res_t           res
);
  import pse_pkg::*;

  localparam int StepW = $clog2(DATA_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r, quo_r[DATA_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
      den_nxt  = den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
      neg_nxt  = num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy_r) begin
      if (!rem_sub[DATA_W]) begin
        rem_nxt = rem_sub[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r + StepW'(1);
      if (step_r == StepW'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign res.done     = done_r;
  assign res.quotient = neg_r ? (~quo_r + DATA_W'(1)) : quo_r;

endmodule
